### sv/ial_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ial_pkg
// Shared widths, codes and controller/datapath command types for the
// indexed array list engine.
// ----------------------------------------------------------------------------
package ial_pkg;

  // Field widths
  localparam int ACT_W = 3;
  localparam int POS_W = 11;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;
  localparam int LEN_W = 11;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_APPEND   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_GET      = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CONTAINS = 3'd4;
  localparam logic [ACT_W-1:0] ACT_CLEAR    = 3'd5;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // Value returned by a get past the end of the list
  localparam logic signed [VAL_W-1:0] VAL_MISS = {VAL_W{1'b1}};

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_INS,
    S_REM,
    S_SRCH,
    S_FIN
  } state_t;

  // Walk pointer operations
  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_LD_CNT,
    PTR_LD_POS,
    PTR_LD_ZERO,
    PTR_INC,
    PTR_DEC
  } ptr_op_t;

  // Read address select
  typedef enum logic [1:0] {
    RD_POS,
    RD_PTR,
    RD_PTR_M1,
    RD_PTR_P1
  } rd_sel_t;

  // Entry count operations
  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLR
  } cnt_op_t;

  // Controller to datapath
  typedef struct packed {
    logic             req_ld;    // latch the accepted request
    ptr_op_t          ptr_op;
    logic             rd_en;
    rd_sel_t          rd_sel;
    logic             pend_set;  // write at ptr next cycle
    logic             pend_val;  // pending write takes the request value
    logic             app_we;    // append write at the count
    logic             cmp_set;   // compare read data next cycle
    logic             hit_clr;
    cnt_op_t          cnt_op;
    logic             st_we;
    logic [ST_W-1:0]  st_code;
    logic             res_ld;    // load the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             full;        // count at capacity
    logic             ins_bad;     // position above count
    logic             idx_bad;     // position at or above count
    logic             ptr_eq_pos;
    logic             ptr_eq_cnt;
    logic             ptr_last;    // ptr + 1 at or above count
    logic             hit_now;
    logic             out_free;
  } sts_t;

endpackage
`default_nettype wire

### sv/ial_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ial_in_if / ial_out_if
// Valid/ready channels carrying list requests and their results.
// ----------------------------------------------------------------------------
interface ial_in_if;
  logic                               valid;
  logic                               ready;
  logic        [ial_pkg::ACT_W-1:0]   action;
  logic        [ial_pkg::POS_W-1:0]   position;
  logic signed [ial_pkg::VAL_W-1:0]   item_value;

  modport source (output valid, action, position, item_value, input ready);
  modport sink   (input valid, action, position, item_value, output ready);
endinterface

interface ial_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [ial_pkg::VAL_W-1:0]   read_value;
  logic                               found;
  logic        [ial_pkg::ST_W-1:0]    status;
  logic        [ial_pkg::LEN_W-1:0]   length_now;

  modport source (output valid, read_value, found, status, length_now, input ready);
  modport sink   (input valid, read_value, found, status, length_now, output ready);
endinterface
`default_nettype wire

### sv/indexed_array_list_engine_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_array_list_engine_top
// Ordered list of signed 32-bit entries in a fixed-capacity store.
// ----------------------------------------------------------------------------
// Each request on in_ch gives exactly one result on out_ch, in order. A
// request is taken in S_IDLE, decoded in S_EXEC in the cycle after, and its
// result is loaded into the output register in S_FIN once the work ends and
// the output register is free. Append, get, clear and unused actions go
// straight from S_EXEC to S_FIN; insert at position p walks from the count
// down to p, remove walks from p up to the end, and contains walks from the
// start until the first match or the end. The walks move one entry per cycle
// through the single read port and single write port of the entry store. A
// new request is taken while a finished result still waits in the output
// register; a result that cannot leave holds the block in its final cycle.
// The store needs no clearing pass after reset; only live entries are ever
// read.
module indexed_array_list_engine_top #(
  parameter int CAPACITY = 1024
) (
  input wire logic  clk,
  input wire logic  rst_n,
  ial_in_if.sink    in_ch,
  ial_out_if.source out_ch
);
  import ial_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ial_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ial_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_action      (in_ch.action),
    .in_position    (in_ch.position),
    .in_item_value  (in_ch.item_value),
    .cmd            (cmd),
    .sts            (sts),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_read_value (out_ch.read_value),
    .out_found      (out_ch.found),
    .out_status     (out_ch.status),
    .out_length_now (out_ch.length_now)
  );

endmodule
`default_nettype wire

### sv/ial_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ial_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ial_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### sv/ial_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ial_datapath
// Request latch, entry count, walk pointer, entry store and result register.
// ----------------------------------------------------------------------------
module ial_datapath #(
  parameter int CAPACITY = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic        [ial_pkg::ACT_W-1:0]  in_action,
  input  wire logic        [ial_pkg::POS_W-1:0]  in_position,
  input  wire logic signed [ial_pkg::VAL_W-1:0]  in_item_value,
  input  wire ial_pkg::cmd_t                     cmd,
  output ial_pkg::sts_t                          sts,
  input  wire logic                              out_ready,
  output logic                                   out_valid,
  output logic signed [ial_pkg::VAL_W-1:0]       out_read_value,
  output logic                                   out_found,
  output logic        [ial_pkg::ST_W-1:0]        out_status,
  output logic        [ial_pkg::LEN_W-1:0]       out_length_now
);
  import ial_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam logic [MW-1:0] CAP_X = MW'(CAPACITY);
  localparam logic [MW-1:0] ONE_X = MW'(1);

  // latched request
  logic [ACT_W-1:0]  act_r;
  logic [POS_W-1:0]  pos_r;
  logic [VAL_W-1:0]  val_r;
  logic [ST_W-1:0]   st_r;

  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     ptr_r, ptr_nxt;
  logic              pend_r, pend_val_r, cmp_pend_r, hit_r;
  logic [AW-1:0]     pend_addr_r;

  logic [MW-1:0]     pos_x, cnt_x, ptr_x;
  logic [AW-1:0]     raddr, waddr;
  logic [VAL_W-1:0]  wdata, rdata;
  logic              we;

  assign pos_x = {{(MW-POS_W){1'b0}}, pos_r};
  assign cnt_x = {{(MW-CW){1'b0}}, cnt_r};
  assign ptr_x = {{(MW-CW){1'b0}}, ptr_r};

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.req_ld) begin
      act_r <= in_action;
      pos_r <= in_position;
      val_r <= in_item_value;
    end
    if (cmd.st_we) begin
      st_r <= cmd.st_code;
    end
  end

  // count and pointer next values
  always_comb begin
    unique case (cmd.cnt_op)
      CNT_INC:  cnt_nxt = cnt_r + CW'(1);
      CNT_DEC:  cnt_nxt = cnt_r - CW'(1);
      CNT_CLR:  cnt_nxt = '0;
      default:  cnt_nxt = cnt_r;
    endcase
  end

  always_comb begin
    unique case (cmd.ptr_op)
      PTR_LD_CNT:  ptr_nxt = cnt_r;
      PTR_LD_POS:  ptr_nxt = pos_x[CW-1:0];
      PTR_LD_ZERO: ptr_nxt = '0;
      PTR_INC:     ptr_nxt = ptr_r + CW'(1);
      PTR_DEC:     ptr_nxt = ptr_r - CW'(1);
      default:     ptr_nxt = ptr_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
  end

  // pending shift write and pending search compare
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r     <= 1'b0;
      cmp_pend_r <= 1'b0;
      hit_r      <= 1'b0;
    end else begin
      pend_r     <= cmd.pend_set;
      cmp_pend_r <= cmd.cmp_set;
      hit_r      <= cmd.hit_clr ? 1'b0 : (hit_r | sts.hit_now);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pend_set) begin
      pend_addr_r <= ptr_r[AW-1:0];
      pend_val_r  <= cmd.pend_val;
    end
  end

  // read address select
  always_comb begin
    unique case (cmd.rd_sel)
      RD_POS:    raddr = pos_x[AW-1:0];
      RD_PTR:    raddr = ptr_r[AW-1:0];
      RD_PTR_M1: raddr = ptr_r[AW-1:0] - AW'(1);
      RD_PTR_P1: raddr = ptr_r[AW-1:0] + AW'(1);
      default:   raddr = ptr_r[AW-1:0];
    endcase
  end

  // write port: append or the pending shift write, never both
  assign we    = cmd.app_we | pend_r;
  assign waddr = cmd.app_we ? cnt_r[AW-1:0] : pend_addr_r;
  assign wdata = (cmd.app_we || pend_val_r) ? val_r : rdata;

  ial_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re      (cmd.rd_en),
    .raddr   (raddr),
    .rdata_r (rdata)
  );

  // status flags
  always_comb begin
    sts.act        = act_r;
    sts.full       = (cnt_x >= CAP_X);
    sts.ins_bad    = (pos_x > cnt_x);
    sts.idx_bad    = (pos_x >= cnt_x);
    sts.ptr_eq_pos = (ptr_x == pos_x);
    sts.ptr_eq_cnt = (ptr_r == cnt_r);
    sts.ptr_last   = ((ptr_x + ONE_X) >= cnt_x);
    sts.hit_now    = cmp_pend_r && (rdata == val_r);
    sts.out_free   = !out_valid || out_ready;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.res_ld) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      if (act_r == ACT_GET) begin
        out_read_value <= (st_r == ST_RANGE) ? VAL_MISS : $signed(rdata);
      end else begin
        out_read_value <= '0;
      end
      out_found      <= hit_r;
      out_status     <= st_r;
      out_length_now <= cnt_x[LEN_W-1:0];
    end
  end

endmodule
`default_nettype wire

### sv/ial_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ial_ctrl
// Request sequencer: decodes the action and steps the store walks.
// ----------------------------------------------------------------------------
module ial_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ial_pkg::sts_t sts,
  output ial_pkg::cmd_t      cmd
);
  import ial_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        unique case (sts.act)
          ACT_INSERT:   state_nxt = (sts.full || sts.ins_bad) ? S_FIN : S_INS;
          ACT_REMOVE:   state_nxt = sts.idx_bad ? S_FIN : S_REM;
          ACT_CONTAINS: state_nxt = S_SRCH;
          default:      state_nxt = S_FIN;
        endcase
      end
      S_INS: begin
        if (sts.ptr_eq_pos) state_nxt = S_FIN;
      end
      S_REM: begin
        if (sts.ptr_last) state_nxt = S_FIN;
      end
      S_SRCH: begin
        if (sts.hit_now || sts.ptr_eq_cnt) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.ptr_op   = PTR_HOLD;
    cmd.rd_sel   = RD_PTR;
    cmd.cnt_op   = CNT_HOLD;
    cmd.st_code  = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.req_ld = in_valid;
      end
      S_EXEC: begin
        cmd.hit_clr = 1'b1;
        cmd.st_we   = 1'b1;
        unique case (sts.act)
          ACT_APPEND: begin
            if (sts.full) begin
              cmd.st_code = ST_FULL;
            end else begin
              cmd.app_we = 1'b1;
              cmd.cnt_op = CNT_INC;
            end
          end
          ACT_INSERT: begin
            if (sts.full)         cmd.st_code = ST_FULL;
            else if (sts.ins_bad) cmd.st_code = ST_RANGE;
            else                  cmd.ptr_op  = PTR_LD_CNT;
          end
          ACT_REMOVE: begin
            if (sts.idx_bad) cmd.st_code = ST_RANGE;
            else             cmd.ptr_op  = PTR_LD_POS;
          end
          ACT_GET: begin
            if (sts.idx_bad) begin
              cmd.st_code = ST_RANGE;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_POS;
            end
          end
          ACT_CONTAINS: cmd.ptr_op = PTR_LD_ZERO;
          ACT_CLEAR:    cmd.cnt_op = CNT_CLR;
          default:      ;
        endcase
      end
      // shift up from the top, then drop the new value at the position
      S_INS: begin
        cmd.pend_set = 1'b1;
        if (sts.ptr_eq_pos) begin
          cmd.pend_val = 1'b1;
          cmd.cnt_op   = CNT_INC;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PTR_M1;
          cmd.ptr_op = PTR_DEC;
        end
      end
      // shift down from the position to the end
      S_REM: begin
        if (sts.ptr_last) begin
          cmd.cnt_op = CNT_DEC;
        end else begin
          cmd.pend_set = 1'b1;
          cmd.rd_en    = 1'b1;
          cmd.rd_sel   = RD_PTR_P1;
          cmd.ptr_op   = PTR_INC;
        end
      end
      // linear search, stops on the first match
      S_SRCH: begin
        if (!(sts.hit_now || sts.ptr_eq_cnt)) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = RD_PTR;
          cmd.cmp_set = 1'b1;
          cmd.ptr_op  = PTR_INC;
        end
      end
      S_FIN: begin
        cmd.res_ld = sts.out_free;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
